// ----- hdl/kom_pkg.sv -----
// Shared constants for the key to offset map allocator.
`timescale 1ns / 1ps
package kom_pkg;
  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned OffW        = 10;
  localparam int unsigned StackDepth  = 1024;
  localparam int unsigned CntW        = 11;
  localparam int unsigned StW         = 4;
  localparam int unsigned CfgAddrW    = 2;

  localparam logic [StW-1:0] ST_HIT          = 4'd0;
  localparam logic [StW-1:0] ST_REUSED       = 4'd1;
  localparam logic [StW-1:0] ST_FRESH        = 4'd2;
  localparam logic [StW-1:0] ST_INVALID_IN   = 4'd3;
  localparam logic [StW-1:0] ST_MISS_INVALID = 4'd4;
  localparam logic [StW-1:0] ST_OVERFLOW     = 4'd5;
  localparam logic [StW-1:0] ST_DP_MISSING   = 4'd6;
  localparam logic [StW-1:0] ST_FREED        = 4'd7;
  localparam logic [StW-1:0] ST_STACK_FULL   = 4'd8;

  localparam logic [CfgAddrW-1:0] CFG_VOCAB   = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_DP      = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_INVALID = 2'd2;

  localparam logic OP_MAP  = 1'b0;
  localparam logic OP_FREE = 1'b1;
endpackage

// ----- hdl/kom_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module kom_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hdl/kom_hash.sv -----
// Folds a key into a home slot index below the table capacity.
`timescale 1ns / 1ps
module kom_hash import kom_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned AddrW    = $clog2(Capacity)
) (
  input  logic [KeyW-1:0]  key_i,
  output logic [AddrW-1:0] slot_o
);
  logic [AddrW-1:0] fold;

  always_comb begin
    fold = '0;
    for (int i = 0; i < int'(KeyW); i++) begin
      fold[i % AddrW] = fold[i % AddrW] ^ key_i[i];
    end
  end

  assign slot_o = ({1'b0, fold} >= (AddrW+1)'(Capacity)) ?
                  AddrW'({1'b0, fold} - (AddrW+1)'(Capacity)) : fold;
endmodule

// ----- hdl/key_to_offset_map_allocator.sv -----
// Key to offset map allocator: top level with hashed slot table and free stack.
// Free and invalid-key words go from the idle state straight to the done state and the output
// register; a map word passes a look and a check state per probe of the open-addressed table
// (1 to CAPACITY probes), the look state covering the registered read of the slot table memory.
// One word at a time: a new word is taken only back in idle, and done waits on a full output.
// Reset: a clearing pass over every slot empties the slot table; no word is
// accepted during it. Config writes are taken at any time.
`timescale 1ns / 1ps
module key_to_offset_map_allocator import kom_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned AddrW    = $clog2(Capacity)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [79:0]         s_axis_tdata,   // key[63:0], freed_offset[73:64], zero pad
  input  logic [1:0]          s_axis_tuser,   // opcode[0], is_train[1]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [71:0]         m_axis_tdata,   // mapped_value[63:0], status[67:64], zero pad
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [KeyW-1:0]     cfg_data_i
);
  localparam int unsigned EntW = 1 + OffW + KeyW;
  localparam int unsigned SAW  = $clog2(StackDepth);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  vocab_q;
  logic             dp_q;
  logic [KeyW-1:0]  inv_q;
  logic [CntW-1:0]  free_cnt_q, free_cnt_d;
  logic [CntW-1:0]  fresh_q, fresh_d;
  logic [AddrW-1:0] idx_q, idx_d, clr_q, probes_q, probes_d, home;
  logic [KeyW-1:0]  key_q, key_d;
  logic             train_q, train_d;
  logic [KeyW-1:0]  res_val_q, res_val_d;
  logic [StW-1:0]   res_st_q, res_st_d;
  logic             ov_q;
  logic [KeyW-1:0]  ov_val_q;
  logic [StW-1:0]   ov_st_q;

  logic             in_op, in_train;
  logic [KeyW-1:0]  in_key;
  logic [OffW-1:0]  in_freed;
  logic             accept;

  logic             tab_we;
  logic [AddrW-1:0] tab_waddr;
  logic [EntW-1:0]  tab_wdata, tab_rdata;
  logic             stk_we;
  logic [OffW-1:0]  stk_rdata;
  logic [CntW-1:0]  limit;
  logic             ent_valid;
  logic [OffW-1:0]  ent_off;
  logic [KeyW-1:0]  ent_key;

  assign in_op    = s_axis_tuser[0];
  assign in_train = s_axis_tuser[1];
  assign in_key   = s_axis_tdata[63:0];
  assign in_freed = s_axis_tdata[73:64];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign ent_valid = tab_rdata[EntW-1];
  assign ent_off   = tab_rdata[KeyW +: OffW];
  assign ent_key   = tab_rdata[KeyW-1:0];
  assign limit     = (vocab_q < CntW'(StackDepth)) ? vocab_q : CntW'(StackDepth);

  kom_hash #(.Capacity(Capacity), .AddrW(AddrW)) u_hash (
    .key_i  (in_key),
    .slot_o (home)
  );

  kom_ram #(.Width(EntW), .Depth(Capacity), .AddrW(AddrW)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (idx_q),
    .rdata_o (tab_rdata)
  );

  kom_ram #(.Width(OffW), .Depth(StackDepth), .AddrW(SAW)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (free_cnt_q[SAW-1:0]),
    .wdata_i (in_freed),
    .raddr_i (SAW'(free_cnt_q - CntW'(1))),
    .rdata_o (stk_rdata)
  );

  assign stk_we = accept && (in_op == OP_FREE) && (free_cnt_q < CntW'(StackDepth));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    probes_d   = probes_q;
    key_d      = key_q;
    train_d    = train_q;
    res_val_d  = res_val_q;
    res_st_d   = res_st_q;
    free_cnt_d = free_cnt_q;
    fresh_d    = fresh_q;
    tab_we     = 1'b0;
    tab_waddr  = clr_q;
    tab_wdata  = '0;
    case (state_q)
      S_CLR: begin
        tab_we = 1'b1;
        if (clr_q == AddrW'(Capacity - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_d    = in_key;
          train_d  = in_train;
          idx_d    = home;
          probes_d = '0;
          if (in_op == OP_FREE) begin
            res_val_d = KeyW'(in_freed);
            if (free_cnt_q < CntW'(StackDepth)) begin
              free_cnt_d = free_cnt_q + CntW'(1);
              res_st_d   = ST_FREED;
            end else begin
              res_st_d   = ST_STACK_FULL;
            end
            state_d = S_DONE;
          end else if (in_key == inv_q) begin
            res_val_d = in_key;
            res_st_d  = ST_INVALID_IN;
            state_d   = S_DONE;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (ent_valid && ent_key == key_q) begin
          res_val_d = KeyW'(ent_off);
          res_st_d  = ST_HIT;
          state_d   = S_DONE;
        end else if (ent_valid && probes_q != AddrW'(Capacity - 1)) begin
          idx_d    = (idx_q == AddrW'(Capacity - 1)) ? '0 : idx_q + AddrW'(1);
          probes_d = probes_q + AddrW'(1);
          state_d  = S_LOOK;
        end else begin
          state_d   = S_DONE;
          res_val_d = inv_q;
          tab_waddr = idx_q;
          if (dp_q) begin
            res_st_d = train_q ? ST_DP_MISSING : ST_MISS_INVALID;
          end else if (!train_q) begin
            res_st_d = ST_MISS_INVALID;
          end else if (ent_valid) begin
            res_st_d = ST_OVERFLOW;
          end else if (free_cnt_q != '0) begin
            free_cnt_d = free_cnt_q - CntW'(1);
            res_val_d  = KeyW'(stk_rdata);
            res_st_d   = ST_REUSED;
            tab_we     = 1'b1;
            tab_wdata  = {1'b1, stk_rdata, key_q};
          end else if (fresh_q >= limit) begin
            res_st_d = ST_OVERFLOW;
          end else begin
            fresh_d   = fresh_q + CntW'(1);
            res_val_d = KeyW'(fresh_q[OffW-1:0]);
            res_st_d  = ST_FRESH;
            tab_we    = 1'b1;
            tab_wdata = {1'b1, fresh_q[OffW-1:0], key_q};
          end
        end
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      free_cnt_q <= '0;
      fresh_q    <= '0;
      vocab_q    <= CntW'(1024);
      dp_q       <= 1'b0;
      inv_q      <= '1;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
      fresh_q    <= fresh_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          CFG_VOCAB:   vocab_q <= cfg_data_i[CntW-1:0];
          CFG_DP:      dp_q    <= cfg_data_i[0];
          CFG_INVALID: inv_q   <= cfg_data_i;
          default:     ;
        endcase
      end
      if (state_q == S_DONE && (!ov_q || m_axis_tready)) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    probes_q  <= probes_d;
    key_q     <= key_d;
    train_q   <= train_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (state_q == S_DONE && (!ov_q || m_axis_tready)) begin
      ov_val_q <= res_val_q;
      ov_st_q  <= res_st_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0, ov_st_q, ov_val_q};

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CntW'(StackDepth))
    else $error("free count above stack depth");
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CntW'(StackDepth))
    else $error("fresh offset above limit");
  a_no_accept_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !s_axis_tready)
    else $error("accept during clearing pass");
  a_look_then_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |=> (state_q == S_CHK))
    else $error("probe read not checked");
endmodule

// ----- bench/key_to_offset_map_allocator_chk.sv -----
// Checker: predicts each result word of the key to offset map and compares it on output.
`timescale 1ns / 1ps
module key_to_offset_map_allocator_chk import kom_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [79:0]         s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [71:0]         m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [KeyW-1:0]     cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  typedef struct packed {
    logic [KeyW-1:0] value;
    logic [StW-1:0]  status;
  } map_result_t;

  map_result_t    result_q[$];
  logic [OffW-1:0] offset_of[logic [KeyW-1:0]];
  logic [OffW-1:0] freed_stack[StackDepth];
  int unsigned    stack_depth;
  int unsigned    fresh_next;
  int unsigned    keys_held;
  logic [CntW-1:0] vocab_size;
  logic           dp_mode;
  logic [KeyW-1:0] invalid_key;
  int             fails;

  function automatic map_result_t map_word(logic op, logic [KeyW-1:0] key, logic train,
                                           logic [OffW-1:0] freed);
    map_result_t r;
    int unsigned limit;
    r.value = '0;
    limit = (vocab_size < StackDepth) ? vocab_size : StackDepth;
    if (op == OP_FREE) begin
      r.value = {{(KeyW-OffW){1'b0}}, freed};
      if (stack_depth < StackDepth) begin
        freed_stack[stack_depth] = freed;
        stack_depth++;
        r.status = ST_FREED;
      end else begin
        r.status = ST_STACK_FULL;
      end
    end else if (key == invalid_key) begin
      r.value  = key;
      r.status = ST_INVALID_IN;
    end else if (offset_of.exists(key)) begin
      r.value  = {{(KeyW-OffW){1'b0}}, offset_of[key]};
      r.status = ST_HIT;
    end else if (dp_mode || !train) begin
      r.value  = invalid_key;
      r.status = (dp_mode && train) ? ST_DP_MISSING : ST_MISS_INVALID;
    end else if (keys_held >= CapacityDef) begin
      r.value  = invalid_key;
      r.status = ST_OVERFLOW;
    end else if (stack_depth > 0) begin
      stack_depth--;
      offset_of[key] = freed_stack[stack_depth];
      keys_held++;
      r.value  = {{(KeyW-OffW){1'b0}}, freed_stack[stack_depth]};
      r.status = ST_REUSED;
    end else if (fresh_next >= limit) begin
      r.value  = invalid_key;
      r.status = ST_OVERFLOW;
    end else begin
      offset_of[key] = fresh_next[OffW-1:0];
      keys_held++;
      r.value  = {{(KeyW-OffW){1'b0}}, fresh_next[OffW-1:0]};
      r.status = ST_FRESH;
      fresh_next++;
    end
    return r;
  endfunction

  assign pending_o    = result_q.size();
  assign fail_count_o = fails;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    map_result_t exp_r;
    if (!rst_ni) begin
      result_q.delete();
      offset_of.delete();
      stack_depth  = 0;
      fresh_next   = 0;
      keys_held    = 0;
      vocab_size   = CntW'(1024);
      dp_mode      = 1'b0;
      invalid_key  = '1;
      fails        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CFG_VOCAB:   vocab_size  = cfg_data_i[CntW-1:0];
          CFG_DP:      dp_mode     = cfg_data_i[0];
          CFG_INVALID: invalid_key = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with none expected: %h", m_axis_tdata);
          fails++;
        end else begin
          exp_r = result_q.pop_front();
          if (m_axis_tdata[63:0] !== exp_r.value) begin
            $error("mapped_value expected %h got %h", exp_r.value, m_axis_tdata[63:0]);
            fails++;
          end
          if (m_axis_tdata[67:64] !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, m_axis_tdata[67:64]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        result_q.insert(result_q.size(),
                        map_word(s_axis_tuser[0], s_axis_tdata[63:0], s_axis_tuser[1],
                                 s_axis_tdata[73:64]));
    end
  end
endmodule

// ----- bench/key_to_offset_map_allocator_tb.sv -----
// Testbench top: drives key map and free words plus config writes, and reports the verdict.
`timescale 1ns / 1ps
module key_to_offset_map_allocator_tb import kom_pkg::*;;
  localparam int StallLimit = 30000;
  localparam int HoldCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [79:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [71:0]         m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [KeyW-1:0]     cfg_data_i;
  int                  fail_count;
  int                  pending;
  int                  stall_pct;
  int                  idle_pct;
  logic                hold_on;
  int                  hold_cnt;
  int                  quiet_cycles;
  logic [KeyW-1:0]     cur_invalid;
  logic [KeyW-1:0]     key_pool[64];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  key_to_offset_map_allocator u_top (.*);

  key_to_offset_map_allocator_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_addr_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
    end else if (hold_on && hold_cnt < HoldCycles) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("key_to_offset_map_allocator_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic op, logic [KeyW-1:0] key, logic train, logic [OffW-1:0] off);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, off, key};
    s_axis_tuser  <= {train, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [KeyW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (addr == CFG_INVALID)
      cur_invalid = data;
  endtask

  task automatic random_words(int n);
    int pick;
    logic [KeyW-1:0] key;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      key  = {$urandom, $urandom};
      if (pick < 8)
        key = cur_invalid;
      else if (pick < 55)
        key = key_pool[$urandom_range(63)];
      send_word(($urandom_range(99) < 20) ? OP_FREE : OP_MAP, key, $urandom_range(99) < 60,
                OffW'($urandom));
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= CFG_VOCAB;
    cfg_data_i    <= '0;
    stall_pct     <= 0;
    hold_on       <= 1'b0;
    quiet_cycles  <= 0;
    idle_pct      = 0;
    cur_invalid   = '1;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: pass-through, fresh, hit, misses, free and reuse, limits, dp mode
    send_word(OP_MAP, '1, 1'b1, '0);
    send_word(OP_MAP, '0, 1'b1, '1);
    send_word(OP_MAP, '0, 1'b0, '0);
    send_word(OP_MAP, 64'd5, 1'b0, '0);
    send_word(OP_MAP, 64'h7fff_ffff_ffff_ffff, 1'b1, '0);
    send_word(OP_MAP, 64'h8000_0000_0000_0000, 1'b1, '0);
    send_word(OP_FREE, 64'd3, 1'b0, 10'd1023);
    send_word(OP_FREE, '1, 1'b1, 10'd0);
    send_word(OP_MAP, 64'd77, 1'b1, '0);
    send_word(OP_MAP, 64'd78, 1'b1, '0);
    write_reg(CFG_VOCAB, 64'd3);
    send_word(OP_MAP, 64'd79, 1'b1, '0);
    write_reg(CFG_VOCAB, 64'd1);
    send_word(OP_MAP, 64'd80, 1'b1, '0);
    write_reg(CFG_VOCAB, 64'd1024);
    write_reg(CFG_DP, 64'd1);
    send_word(OP_MAP, '0, 1'b1, '0);
    send_word(OP_MAP, 64'd99, 1'b1, '0);
    send_word(OP_MAP, 64'd99, 1'b0, '0);
    send_word(OP_FREE, 64'd0, 1'b1, 10'd512);
    send_word(OP_MAP, '1, 1'b0, '0);
    write_reg(CFG_DP, 64'd0);
    send_word(OP_MAP, 64'd100, 1'b1, '0);

    write_reg(CFG_INVALID, {$urandom, $urandom});
    random_words(150);
    write_reg(CFG_VOCAB, 64'($urandom_range(1024, 1)));
    idle_pct = 70;
    random_words(150);
    write_reg(CFG_DP, 64'd1);
    idle_pct = 0;
    stall_pct <= 70;
    random_words(150);
    write_reg(CFG_DP, 64'd0);
    write_reg(CFG_INVALID, 64'h8000_0000_0000_0000);
    write_reg(CFG_VOCAB, 64'd1024);
    idle_pct = 27;
    stall_pct <= 27;
    random_words(150);

    drain();
    idle_pct = 0;
    stall_pct <= 0;
    hold_on <= 1'b1;
    random_words(40);

    // fill the slot table past its capacity, then miss with offsets left on the stack
    write_reg(CFG_INVALID, 64'h7fff_ffff_ffff_ffff);
    for (int i = 0; i < 1040; i++)
      send_word(OP_MAP, {$urandom, $urandom}, 1'b1, OffW'($urandom));
    for (int i = 0; i < 4; i++)
      send_word(OP_FREE, {$urandom, $urandom}, 1'b0, OffW'($urandom));
    for (int i = 0; i < 4; i++)
      send_word(OP_MAP, {$urandom, $urandom}, 1'b1, '0);
    send_word(OP_MAP, key_pool[0], 1'b0, '0);

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0)
      $display("key_to_offset_map_allocator_tb passed");
    else
      $display("key_to_offset_map_allocator_tb failed");
    $finish;
  end
endmodule
